[design/ipmd_pkg.sv]
// Package for the incremental PID motor drive: register indexes, reset values,
// constant-divisor helpers and the structs shared by the top level and the PID datapath.
// Depends on nothing.
package ipmd_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 10;

  // Run count limit; a run tick with the count already at this value arms the drive.
  localparam logic [9:0] ARM_TICKS = 10'd600;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_PROP     = 3'd0,
    REG_GAIN_INTEG    = 3'd1,
    REG_GAIN_DERIV    = 3'd2,
    REG_FORWARD_LIMIT = 3'd3,
    REG_REVERSE_LIMIT = 3'd4,
    REG_BRAKE_DUTY    = 3'd5,
    REG_START_DELAY   = 3'd6,
    REG_BRAKE_TICKS   = 3'd7
  } cfg_reg_e;

  localparam logic [7:0] RST_GAIN_PROP     = 8'd20;
  localparam logic [7:0] RST_GAIN_INTEG    = 8'd20;
  localparam logic [7:0] RST_GAIN_DERIV    = 8'd10;
  localparam logic [7:0] RST_FORWARD_LIMIT = 8'd200;
  localparam logic [7:0] RST_REVERSE_LIMIT = 8'd100;
  localparam logic [7:0] RST_BRAKE_DUTY    = 8'd150;
  localparam logic [9:0] RST_START_DELAY   = 10'd300;
  localparam logic [9:0] RST_BRAKE_TICKS   = 10'd200;

  // Reciprocals for exact division of values below 2**20 by 15 and by 25.
  localparam logic [20:0] RECIP15 = 21'd1118482;
  localparam logic [20:0] RECIP25 = 21'd1342178;

  typedef struct packed {
    logic [7:0] prop;
    logic [7:0] integ;
    logic [7:0] deriv;
  } ipmd_gains_t;

  typedef struct packed {
    logic load_prod;
    logic load_inc;
  } ipmd_ctrl_t;

  // Floor of a 21-bit magnitude divided by 30: halve, then divide by 15.
  function automatic logic [15:0] div30(input logic [20:0] mag);
    logic [40:0] prod;
    prod = {21'd0, mag[20:1]} * {20'd0, RECIP15};
    return prod[39:24];
  endfunction

  // Floor of a 21-bit magnitude divided by 50: halve, then divide by 25.
  function automatic logic [15:0] div50(input logic [20:0] mag);
    logic [40:0] prod;
    prod = {21'd0, mag[20:1]} * {20'd0, RECIP25};
    return prod[40:25];
  endfunction

endpackage

[design/ipmd_pid.sv]
// PID increment datapath: error history, gain products and the truncating divisions.
// Two register stages; uses ipmd_pkg for the gain and control structs and the dividers.
module ipmd_pid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ipmd_pkg::ipmd_ctrl_t ctrl_i,
  input  ipmd_pkg::ipmd_gains_t gains_i,
  input  logic [9:0]         target_speed_i,
  input  logic [10:0]        measured_speed_i,
  output logic signed [17:0] inc_o
);
  import ipmd_pkg::*;

  logic signed [12:0] last_err_q, older_err_q;
  logic signed [13:0] err, d1, d2;
  logic [12:0] mag_err, mag_d1, mag_d2;
  logic [20:0] mag_prop_q, mag_integ_q, mag_deriv_q;
  logic [2:0] neg_q;
  logic [15:0] q_prop, q_integ, q_deriv;
  logic signed [17:0] s_prop, s_integ, s_deriv;
  logic signed [17:0] inc_q;

  always_comb begin
    err = $signed({4'd0, target_speed_i}) - $signed({3'd0, measured_speed_i});
    d1 = err - {last_err_q[12], last_err_q};
    d2 = err - {last_err_q, 1'b0} + {older_err_q[12], older_err_q};
    mag_err = err[13] ? 13'(-err) : err[12:0];
    mag_d1 = d1[13] ? 13'(-d1) : d1[12:0];
    mag_d2 = d2[13] ? 13'(-d2) : d2[12:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      older_err_q <= '0;
    end else if (ctrl_i.load_prod) begin
      last_err_q <= err[12:0];
      older_err_q <= last_err_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_prod) begin
      mag_prop_q <= {8'd0, mag_d1} * {13'd0, gains_i.prop};
      mag_integ_q <= {8'd0, mag_err} * {13'd0, gains_i.integ};
      mag_deriv_q <= {8'd0, mag_d2} * {13'd0, gains_i.deriv};
      neg_q <= {d2[13], err[13], d1[13]};
    end
  end

  always_comb begin
    q_prop = div30(mag_prop_q);
    q_integ = div30(mag_integ_q);
    q_deriv = div50(mag_deriv_q);
    s_prop = neg_q[0] ? -$signed({2'd0, q_prop}) : $signed({2'd0, q_prop});
    s_integ = neg_q[1] ? -$signed({2'd0, q_integ}) : $signed({2'd0, q_integ});
    s_deriv = neg_q[2] ? -$signed({2'd0, q_deriv}) : $signed({2'd0, q_deriv});
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_inc) begin
      inc_q <= s_prop + s_integ + s_deriv;
    end
  end

  assign inc_o = inc_q;

endmodule

[design/incremental_pid_motor_drive_unit.sv]
// Incremental PID motor drive: configuration registers, pipeline control and the output
// stage with clamping, run gating, start delay, arming and timed braking.
// Depends on ipmd_pkg and ipmd_pid.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    target_speed, measured_speed, run, brake
//   out      output     out_valid_o / out_stall_i  forward_duty, reverse_duty, armed
//   cfg      input      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// One transaction is accepted per cycle while in_stall_o is low; results emerge in order.
// The held forward duty, run counter and brake counter close their loops in the output stage.
// A stalled output stage lets the two earlier stages fill before in_stall_o rises.
// Reset restores the register defaults and clears the error history and counters.
module incremental_pid_motor_drive_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ipmd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ipmd_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [9:0]                    target_speed_i,
  input  logic [10:0]                   measured_speed_i,
  input  logic                          run_enable_i,
  input  logic                          brake_request_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    forward_duty_o,
  output logic [7:0]                    reverse_duty_o,
  output logic                          armed_o
);
  import ipmd_pkg::*;

  ipmd_gains_t gains_q;
  logic [7:0] fwd_limit_q, rev_limit_q, brake_duty_q;
  logic [9:0] start_delay_q, brake_ticks_q;

  logic v1_q, v2_q, v3_q;
  logic ready1, ready2, ready3, accept;
  ipmd_ctrl_t ctrl;
  logic [1:0] side1_q, side2_q;
  logic signed [17:0] inc;

  logic [7:0] fwd_q, rev_q;
  logic armed_q;
  logic [9:0] run_ticks_q, brake_cnt_q;

  logic signed [18:0] sum, clip, neg_sum;
  logic [7:0] fwd_d, rev_d;
  logic armed_d;
  logic [9:0] run_ticks_d, brake_cnt_d;
  logic [10:0] n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.prop <= RST_GAIN_PROP;
      gains_q.integ <= RST_GAIN_INTEG;
      gains_q.deriv <= RST_GAIN_DERIV;
      fwd_limit_q <= RST_FORWARD_LIMIT;
      rev_limit_q <= RST_REVERSE_LIMIT;
      brake_duty_q <= RST_BRAKE_DUTY;
      start_delay_q <= RST_START_DELAY;
      brake_ticks_q <= RST_BRAKE_TICKS;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_GAIN_PROP:     gains_q.prop <= cfg_wdata_i[7:0];
        REG_GAIN_INTEG:    gains_q.integ <= cfg_wdata_i[7:0];
        REG_GAIN_DERIV:    gains_q.deriv <= cfg_wdata_i[7:0];
        REG_FORWARD_LIMIT: fwd_limit_q <= cfg_wdata_i[7:0];
        REG_REVERSE_LIMIT: rev_limit_q <= cfg_wdata_i[7:0];
        REG_BRAKE_DUTY:    brake_duty_q <= cfg_wdata_i[7:0];
        REG_START_DELAY:   start_delay_q <= cfg_wdata_i;
        REG_BRAKE_TICKS:   brake_ticks_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign ready3 = !v3_q || !out_stall_i;
  assign ready2 = !v2_q || ready3;
  assign ready1 = !v1_q || ready2;
  assign in_stall_o = !ready1;
  assign accept = in_valid_i && ready1;
  assign ctrl.load_prod = accept;
  assign ctrl.load_inc = v1_q && ready2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      side1_q <= {brake_request_i, run_enable_i};
    end
    if (ctrl.load_inc) begin
      side2_q <= side1_q;
    end
  end

  ipmd_pid u_pid (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .gains_i          (gains_q),
    .target_speed_i   (target_speed_i),
    .measured_speed_i (measured_speed_i),
    .inc_o            (inc)
  );

  always_comb begin
    sum = $signed({11'd0, fwd_q}) + $signed({inc[17], inc});
    clip = (sum > $signed({11'd0, fwd_limit_q})) ? $signed({11'd0, fwd_limit_q}) : sum;
    neg_sum = -clip;
    if (!clip[18]) begin
      fwd_d = clip[7:0];
      rev_d = 8'd0;
    end else begin
      fwd_d = 8'd0;
      rev_d = (neg_sum > $signed({11'd0, rev_limit_q})) ? rev_limit_q : neg_sum[7:0];
    end

    armed_d = armed_q;
    run_ticks_d = run_ticks_q;
    n = {1'b0, run_ticks_q} + 11'd1;
    if (!side2_q[0]) begin
      fwd_d = 8'd0;
      rev_d = 8'd0;
    end else begin
      if (n < {1'b0, start_delay_q}) begin
        fwd_d = 8'd0;
        rev_d = 8'd0;
      end
      if (n > {1'b0, ARM_TICKS}) begin
        n = {1'b0, ARM_TICKS};
        armed_d = 1'b1;
      end
      run_ticks_d = n[9:0];
    end

    brake_cnt_d = brake_cnt_q;
    if (side2_q[1]) begin
      if (brake_cnt_q < brake_ticks_q) begin
        brake_cnt_d = brake_cnt_q + 10'd1;
      end
      fwd_d = 8'd0;
      rev_d = (brake_cnt_d < brake_ticks_q) ? brake_duty_q : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 8'd0;
      armed_q <= 1'b0;
      run_ticks_q <= 10'd0;
      brake_cnt_q <= 10'd0;
    end else if (v2_q && ready3) begin
      fwd_q <= fwd_d;
      armed_q <= armed_d;
      run_ticks_q <= run_ticks_d;
      brake_cnt_q <= brake_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && ready3) begin
      rev_q <= rev_d;
    end
  end

  assign out_valid_o = v3_q;
  assign forward_duty_o = fwd_q;
  assign reverse_duty_o = rev_q;
  assign armed_o = armed_q;

  a_armed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |=> armed_q)
    else $error("armed flag dropped");

  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (forward_duty_o == 8'd0 || reverse_duty_o == 8'd0))
    else $error("forward and reverse duty both driven");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_ticks_q <= ARM_TICKS)
    else $error("run counter beyond arm time");

  a_armed_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(armed_q) |-> run_ticks_q == ARM_TICKS)
    else $error("armed without reaching arm time");

endmodule

[test/tb_incremental_pid_motor_drive_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for incremental_pid_motor_drive_unit: a directed part, then random
// control ticks across several register settings, checked against a predictor of the drive.
// Depends on ipmd_pkg and the design files under design.
module tb_incremental_pid_motor_drive_unit;
  import ipmd_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned TicksPerPhase = 94;

  typedef struct packed {
    logic [9:0]  target;
    logic [10:0] measured;
    logic        run;
    logic        brake;
  } tick_t;

  typedef struct packed {
    logic [7:0] fwd;
    logic [7:0] rev;
    logic       armed;
  } duty_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [9:0]          target_speed_i;
  logic [10:0]         measured_speed_i;
  logic                run_enable_i;
  logic                brake_request_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          forward_duty_o;
  logic [7:0]          reverse_duty_o;
  logic                armed_o;

  incremental_pid_motor_drive_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .target_speed_i   (target_speed_i),
    .measured_speed_i (measured_speed_i),
    .run_enable_i     (run_enable_i),
    .brake_request_i  (brake_request_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .forward_duty_o   (forward_duty_o),
    .reverse_duty_o   (reverse_duty_o),
    .armed_o          (armed_o)
  );

  // Predictor copy of the registers and the loop state.
  logic [7:0] gain_prop_q, gain_integ_q, gain_deriv_q;
  logic [7:0] fwd_limit_q, rev_limit_q, brake_duty_q;
  logic [9:0] start_delay_q, brake_ticks_q;
  int         last_err_q, older_err_q;
  logic [7:0] held_fwd_q;
  logic [9:0] run_ticks_q, brake_count_q;
  logic       armed_q;

  logic [9:0] next_cfg [8];
  duty_t      duty_queue [$];
  int         error_count = 0;
  int         quiet_cycles = 0;
  int         calm_ticks = 0;
  int         stall_left = 0;
  int         calm_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic duty_t predict_duty(tick_t t);
    int    e, e1, e2, inc, sum, fwd, rev, n, c;
    duty_t d;
    e  = int'(t.target) - int'(t.measured);
    e1 = last_err_q;
    e2 = older_err_q;
    inc = (int'(gain_prop_q) * (e - e1)) / 30 + (int'(gain_integ_q) * e) / 30
        + (int'(gain_deriv_q) * (e - 2 * e1 + e2)) / 50;
    older_err_q = e1;
    last_err_q  = e;
    sum = int'(held_fwd_q) + inc;
    if (sum > int'(fwd_limit_q)) sum = int'(fwd_limit_q);
    if (sum >= 0) begin
      fwd = sum;
      rev = 0;
    end else begin
      if (sum < -int'(rev_limit_q)) sum = -int'(rev_limit_q);
      fwd = 0;
      rev = -sum;
    end
    if (!t.run) begin
      fwd = 0;
      rev = 0;
    end else begin
      n = int'(run_ticks_q) + 1;
      if (n < int'(start_delay_q)) begin
        fwd = 0;
        rev = 0;
      end
      if (n > int'(ARM_TICKS)) begin
        n = int'(ARM_TICKS);
        armed_q = 1'b1;
      end
      run_ticks_q = 10'(n);
    end
    if (t.brake) begin
      c = int'(brake_count_q);
      if (c < int'(brake_ticks_q)) c++;
      brake_count_q = 10'(c);
      fwd = 0;
      rev = (c < int'(brake_ticks_q)) ? int'(brake_duty_q) : 0;
    end
    held_fwd_q = 8'(fwd);
    d.fwd   = 8'(fwd);
    d.rev   = 8'(rev);
    d.armed = armed_q;
    return d;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_ticks > 0) begin
      calm_ticks--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm_ticks = $urandom_range(30, 80);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic tick_t random_tick(logic brake);
    tick_t t;
    int    m;
    t.target = 10'($urandom_range(0, 1023));
    if ($urandom_range(0, 99) < 35) begin
      t.measured = 11'($urandom_range(0, 2047));
    end else begin
      m = int'(t.target) + $urandom_range(0, 40) - 20;
      if (m < 0) m = 0;
      t.measured = 11'(m);
    end
    t.run   = ($urandom_range(0, 99) < 92);
    t.brake = brake;
    return t;
  endfunction

  task automatic send_tick(tick_t t, int gap);
    target_speed_i   <= t.target;
    measured_speed_i <= t.measured;
    run_enable_i     <= t.run;
    brake_request_i  <= t.brake;
    in_valid_i       <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    duty_queue.push_back(predict_duty(t));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (duty_queue.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic apply_config();
    drain_pipeline();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_reg_e'(i);
      cfg_wdata_i <= next_cfg[i];
      @(posedge clk_i);
      case (cfg_reg_e'(i))
        REG_GAIN_PROP:     gain_prop_q   = next_cfg[i][7:0];
        REG_GAIN_INTEG:    gain_integ_q  = next_cfg[i][7:0];
        REG_GAIN_DERIV:    gain_deriv_q  = next_cfg[i][7:0];
        REG_FORWARD_LIMIT: fwd_limit_q   = next_cfg[i][7:0];
        REG_REVERSE_LIMIT: rev_limit_q   = next_cfg[i][7:0];
        REG_BRAKE_DUTY:    brake_duty_q  = next_cfg[i][7:0];
        REG_START_DELAY:   start_delay_q = next_cfg[i];
        REG_BRAKE_TICKS:   brake_ticks_q = next_cfg[i];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_tick('{10'd1023, 11'd0, 1'b1, 1'b0}, 0);
    send_tick('{10'd0, 11'd2047, 1'b1, 1'b0}, 1);
    send_tick('{10'd512, 11'd512, 1'b0, 1'b0}, 0);
  endtask

  task automatic test_field_extremes();
    next_cfg[REG_GAIN_PROP]     = 10'd255;
    next_cfg[REG_GAIN_INTEG]    = 10'd255;
    next_cfg[REG_GAIN_DERIV]    = 10'd255;
    next_cfg[REG_FORWARD_LIMIT] = 10'd255;
    next_cfg[REG_REVERSE_LIMIT] = 10'd255;
    next_cfg[REG_START_DELAY]   = 10'd0;
    apply_config();
    send_tick('{10'd1023, 11'd0, 1'b1, 1'b0}, 0);
    send_tick('{10'd1023, 11'd0, 1'b1, 1'b0}, 0);
    send_tick('{10'd0, 11'd2047, 1'b1, 1'b0}, 2);
    send_tick('{10'd0, 11'd0, 1'b1, 1'b0}, 0);
    send_tick('{10'd1023, 11'd1023, 1'b0, 1'b0}, 0);
    send_tick('{10'd0, 11'd2047, 1'b0, 1'b0}, 0);
    send_tick('{10'd600, 11'd590, 1'b1, 1'b0}, 0);
    send_tick('{10'd590, 11'd600, 1'b1, 1'b0}, 0);
  endtask

  task automatic test_start_delay();
    next_cfg[REG_GAIN_PROP]     = 10'd20;
    next_cfg[REG_GAIN_INTEG]    = 10'd40;
    next_cfg[REG_FORWARD_LIMIT] = 10'd200;
    next_cfg[REG_START_DELAY]   = run_ticks_q + 10'd3;
    apply_config();
    repeat (4) send_tick('{10'd700, 11'd400, 1'b1, 1'b0}, 0);
  endtask

  task automatic test_braking();
    next_cfg[REG_BRAKE_DUTY]  = 10'd255;
    next_cfg[REG_BRAKE_TICKS] = brake_count_q + 10'd3;
    apply_config();
    repeat (4) send_tick('{10'd800, 11'd100, 1'b1, 1'b1}, 0);
    send_tick('{10'd800, 11'd100, 1'b0, 1'b1}, 0);
  endtask

  task automatic test_random();
    logic brake;
    int   r;
    for (int p = 0; p < RandomPhases; p++) begin
      for (int i = 0; i < 8; i++) begin
        if (p == 0) begin
          next_cfg[i] = 10'd0;
        end else if (p == 1) begin
          next_cfg[i] = (i >= REG_START_DELAY) ? 10'd1023 : 10'd255;
        end else begin
          r = $urandom_range(0, 9);
          if (i == REG_START_DELAY) begin
            next_cfg[i] = (r == 0) ? 10'd1023 : 10'($urandom_range(0, 40));
          end else if (i == REG_BRAKE_TICKS) begin
            next_cfg[i] = (r == 0) ? 10'd1023 : 10'($urandom_range(0, 120));
          end else begin
            next_cfg[i] = {2'($urandom), 8'($urandom)};
            if (r == 0) next_cfg[i][7:0] = 8'd0;
            if (r == 1) next_cfg[i][7:0] = 8'd255;
          end
        end
      end
      apply_config();
      brake = 1'b0;
      for (int i = 0; i < TicksPerPhase; i++) begin
        if ($urandom_range(0, 29) == 0) brake = ~brake;
        if ($urandom_range(0, 149) == 0) drain_pipeline();
        send_tick(random_tick(brake), pick_gap());
      end
    end
  endtask

  // Result checker, watchdog counter and random back-pressure.
  always @(posedge clk_i) begin
    duty_t exp_duty;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid_o && !out_stall_i) begin
        if (duty_queue.size() == 0) begin
          $error("result transaction with nothing expected");
          error_count++;
        end else begin
          exp_duty = duty_queue.pop_front();
          if (forward_duty_o !== exp_duty.fwd) begin
            $error("forward_duty expected %0d, got %0d", exp_duty.fwd, forward_duty_o);
            error_count++;
          end
          if (reverse_duty_o !== exp_duty.rev) begin
            $error("reverse_duty expected %0d, got %0d", exp_duty.rev, reverse_duty_o);
            error_count++;
          end
          if (armed_o !== exp_duty.armed) begin
            $error("armed expected %0d, got %0d", exp_duty.armed, armed_o);
            error_count++;
          end
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (calm_cycles > 0) begin
      calm_cycles--;
      out_stall_i <= 1'b0;
    end else begin
      case ($urandom_range(0, 199)) inside
        [0:1]:     calm_cycles = $urandom_range(50, 150);
        [2:24]:    stall_left = $urandom_range(0, 2);
        [25:29]:   stall_left = $urandom_range(4, 30);
        default: ;
      endcase
      out_stall_i <= (stall_left > 0) || ($urandom_range(0, 199) inside {[2:29]});
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin
    wait (rst_ni);
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("incremental_pid_motor_drive_unit verification failed");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = REG_GAIN_PROP;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    target_speed_i   = '0;
    measured_speed_i = '0;
    run_enable_i     = 1'b0;
    brake_request_i  = 1'b0;
    gain_prop_q   = RST_GAIN_PROP;
    gain_integ_q  = RST_GAIN_INTEG;
    gain_deriv_q  = RST_GAIN_DERIV;
    fwd_limit_q   = RST_FORWARD_LIMIT;
    rev_limit_q   = RST_REVERSE_LIMIT;
    brake_duty_q  = RST_BRAKE_DUTY;
    start_delay_q = RST_START_DELAY;
    brake_ticks_q = RST_BRAKE_TICKS;
    last_err_q    = 0;
    older_err_q   = 0;
    held_fwd_q    = '0;
    run_ticks_q   = '0;
    brake_count_q = '0;
    armed_q       = 1'b0;
    next_cfg[REG_GAIN_PROP]     = 10'(RST_GAIN_PROP);
    next_cfg[REG_GAIN_INTEG]    = 10'(RST_GAIN_INTEG);
    next_cfg[REG_GAIN_DERIV]    = 10'(RST_GAIN_DERIV);
    next_cfg[REG_FORWARD_LIMIT] = 10'(RST_FORWARD_LIMIT);
    next_cfg[REG_REVERSE_LIMIT] = 10'(RST_REVERSE_LIMIT);
    next_cfg[REG_BRAKE_DUTY]    = 10'(RST_BRAKE_DUTY);
    next_cfg[REG_START_DELAY]   = RST_START_DELAY;
    next_cfg[REG_BRAKE_TICKS]   = RST_BRAKE_TICKS;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_field_extremes();
    test_start_delay();
    test_braking();
    test_random();
    drain_pipeline();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("incremental_pid_motor_drive_unit verification clean");
    end else begin
      $display("incremental_pid_motor_drive_unit verification failed");
    end
    $finish;
  end

endmodule
